/* rtl/core/prip_pkg.sv */
// ============================================================================
// prip_pkg: shared types and constants of the page reuse interval profiler
// Beat layouts, table entry layout, sequencer states and field widths.
// ============================================================================
`default_nettype none

package prip_pkg;

  localparam int PAGE_BITS         = 36;
  localparam int TIME_BITS         = 48;
  localparam int OUT_CNT_BITS      = 11;
  localparam int REUSE_BITS        = 32;
  localparam int ACCESS_BITS       = 32;
  localparam int SUM_BITS          = 64;
  localparam int TABLE_ENTRIES_DEF = 1024;

  typedef struct packed {
    logic [PAGE_BITS-1:0] page_number;
    logic [TIME_BITS-1:0] access_time;
    logic                 trace_end;
  } in_item_t;

  typedef struct packed {
    logic                    first_touch;
    logic [TIME_BITS-1:0]    reuse_interval;
    logic [OUT_CNT_BITS-1:0] stored_pages;
    logic [OUT_CNT_BITS-1:0] single_pages;
    logic [REUSE_BITS-1:0]   reuse_total;
    logic [SUM_BITS-1:0]     interval_sum;
    logic [ACCESS_BITS-1:0]  access_total;
    logic [TIME_BITS-1:0]    mean_interval;
    logic                    table_overflow;
    logic                    final_result;
  } out_item_t;

  typedef struct packed {
    logic                 valid;
    logic                 seen_again;
    logic [PAGE_BITS-1:0] tag;
    logic [TIME_BITS-1:0] last_time;
  } table_entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_UPDATE,
    ST_DIV_LOAD,
    ST_DIVIDE,
    ST_RESULT
  } state_t;

endpackage

`default_nettype wire

/* rtl/core/prip_table.sv */
// ============================================================================
// prip_table: page table storage
// Single-port-write, single-port-read memory of table entries with a
// registered read.
// ============================================================================
`default_nettype none

module prip_table #(
  parameter int TABLE_ENTRIES = prip_pkg::TABLE_ENTRIES_DEF,
  parameter int IDX_BITS      = $clog2(TABLE_ENTRIES)
) (
  input  wire                          clk,
  input  wire                          wr_en,
  input  wire [IDX_BITS-1:0]           wr_addr,
  input  wire prip_pkg::table_entry_t  wr_data,
  input  wire [IDX_BITS-1:0]           rd_addr,
  output prip_pkg::table_entry_t       rd_data
);

  prip_pkg::table_entry_t mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* rtl/core/prip_divider.sv */
// ============================================================================
// prip_divider: iterative unsigned divider
// Restoring division of the interval sum by the reuse count, one quotient
// bit per cycle through a single shared subtractor.
// ============================================================================
`default_nettype none

module prip_divider (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            start,
  input  wire [prip_pkg::SUM_BITS-1:0]   dividend,
  input  wire [prip_pkg::REUSE_BITS-1:0] divisor,
  output logic                           done,
  output logic [prip_pkg::SUM_BITS-1:0]  quotient
);

  localparam int SB        = prip_pkg::SUM_BITS;
  localparam int RB        = prip_pkg::REUSE_BITS;
  localparam int STEP_BITS = $clog2(SB);
  localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(SB - 1);

  logic                 busy;
  logic [STEP_BITS-1:0] step;
  logic [RB-1:0]        rem;
  logic [RB-1:0]        div_q;
  logic [RB:0]          trial;
  logic [RB:0]          diff;
  logic                 qbit;
  logic [RB-1:0]        rem_next;

  // The dividend shifts out of the top of the quotient register while
  // quotient bits shift in at the bottom.
  always_comb begin
    trial    = {rem, quotient[SB-1]};
    diff     = trial - {1'b0, div_q};
    qbit     = (trial >= {1'b0, div_q});
    rem_next = qbit ? diff[RB-1:0] : trial[RB-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      div_q    <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= rem_next;
      quotient <= {quotient[SB-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst) begin
      if (start && busy) begin
        $error("divider started while a division is still running");
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/page_reuse_interval_profiler.sv */
// Sequence: a beat is accepted in IDLE, then READ and CHECK probe its hashed slot,
//   once more per extra probe (up to TABLE_ENTRIES - 1 of them when the table is
//   full), then UPDATE; a trace-end beat with reuses divides before RESULT registers it.
// Beats: one at a time; a new beat is taken only back in IDLE, and RESULT waits on
//   result_ready. Reset and every trace end run a clearing sweep of every table entry,
//   one entry per cycle, with item_ready low.
// ============================================================================
// page_reuse_interval_profiler: per-page reuse interval statistics
// Hashed, linearly probed page table with a sequencer, running counters and
// an iterative divider for the mean reuse interval at trace end.
// ============================================================================
`default_nettype none

module page_reuse_interval_profiler #(
  parameter int TABLE_ENTRIES = prip_pkg::TABLE_ENTRIES_DEF
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      item_valid,
  output logic                     item_ready,
  input  wire prip_pkg::in_item_t  item,
  output logic                     result_valid,
  input  wire                      result_ready,
  output prip_pkg::out_item_t      result
);

  localparam int PB       = prip_pkg::PAGE_BITS;
  localparam int TB       = prip_pkg::TIME_BITS;
  localparam int SB       = prip_pkg::SUM_BITS;
  localparam int RB       = prip_pkg::REUSE_BITS;
  localparam int AB       = prip_pkg::ACCESS_BITS;
  localparam int OCB      = prip_pkg::OUT_CNT_BITS;
  localparam int IDX_BITS = $clog2(TABLE_ENTRIES);
  localparam int CNT_BITS = $clog2(TABLE_ENTRIES + 1);

  localparam logic [IDX_BITS-1:0] LAST_IDX   = IDX_BITS'(TABLE_ENTRIES - 1);
  localparam logic [CNT_BITS-1:0] LAST_PROBE = CNT_BITS'(TABLE_ENTRIES - 1);
  localparam logic [IDX_BITS:0]   ENTRIES_W  = (IDX_BITS + 1)'(TABLE_ENTRIES);

  prip_pkg::state_t state, state_next;

  prip_pkg::in_item_t     cur;
  prip_pkg::table_entry_t rd_entry;
  prip_pkg::table_entry_t wr_entry;
  logic                   wr_en;
  logic [IDX_BITS-1:0]    wr_addr;
  logic                   div_start;
  logic                   div_done;
  logic [SB-1:0]          div_quotient;

  logic [IDX_BITS-1:0] probe_idx;
  logic [CNT_BITS-1:0] probes;
  logic [IDX_BITS-1:0] clr_idx;
  logic                hit;
  logic                insert;
  logic                dec_single;
  logic [TB-1:0]       interval;
  logic [CNT_BITS-1:0] used;
  logic [CNT_BITS-1:0] single;
  logic [RB-1:0]       reuse;
  logic [SB-1:0]       sum;
  logic [AB-1:0]       access;
  logic [TB-1:0]       mean;

  logic                match;
  logic                probe_end;
  logic [IDX_BITS-1:0] fold;
  logic [IDX_BITS:0]   fold_w;
  logic [IDX_BITS-1:0] hash_idx;
  logic [SB:0]         sum_wide;

  // Fold the page number down to an index, then bring it below the table size.
  always_comb begin
    fold = '0;
    for (int i = 0; i < PB; i++) begin
      fold[i % IDX_BITS] = fold[i % IDX_BITS] ^ item.page_number[i];
    end
    fold_w   = {1'b0, fold};
    hash_idx = (fold_w >= ENTRIES_W) ? IDX_BITS'(fold_w - ENTRIES_W) : fold;
  end

  assign match     = rd_entry.valid && (rd_entry.tag == cur.page_number);
  assign probe_end = match || !rd_entry.valid || (probes == LAST_PROBE);
  assign sum_wide  = {1'b0, sum} + (SB + 1)'(interval);

  prip_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .IDX_BITS     (IDX_BITS)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_entry),
    .rd_addr(probe_idx),
    .rd_data(rd_entry)
  );

  prip_divider u_divider (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(sum),
    .divisor (reuse),
    .done    (div_done),
    .quotient(div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prip_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next          = state;
    item_ready          = 1'b0;
    wr_en               = 1'b0;
    wr_addr             = probe_idx;
    wr_entry.valid      = 1'b1;
    wr_entry.seen_again = match;
    wr_entry.tag        = cur.page_number;
    wr_entry.last_time  = cur.access_time;
    div_start           = 1'b0;
    unique case (state)
      prip_pkg::ST_CLEAR: begin
        wr_en          = 1'b1;
        wr_addr        = clr_idx;
        wr_entry.valid = 1'b0;
        if (clr_idx == LAST_IDX) begin
          state_next = prip_pkg::ST_IDLE;
        end
      end
      prip_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          state_next = prip_pkg::ST_READ;
        end
      end
      prip_pkg::ST_READ: begin
        state_next = prip_pkg::ST_CHECK;
      end
      prip_pkg::ST_CHECK: begin
        // A free slot met while probing is where a new page goes.
        wr_en      = match || !rd_entry.valid;
        state_next = probe_end ? prip_pkg::ST_UPDATE : prip_pkg::ST_READ;
      end
      prip_pkg::ST_UPDATE: begin
        if (cur.trace_end && (hit || (reuse != '0))) begin
          state_next = prip_pkg::ST_DIV_LOAD;
        end else begin
          state_next = prip_pkg::ST_RESULT;
        end
      end
      prip_pkg::ST_DIV_LOAD: begin
        div_start  = 1'b1;
        state_next = prip_pkg::ST_DIVIDE;
      end
      prip_pkg::ST_DIVIDE: begin
        if (div_done) begin
          state_next = prip_pkg::ST_RESULT;
        end
      end
      prip_pkg::ST_RESULT: begin
        if (!result_valid || result_ready) begin
          state_next = cur.trace_end ? prip_pkg::ST_CLEAR : prip_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = prip_pkg::ST_CLEAR;
      end
    endcase
  end

  // Control registers and running statistics.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx      <= '0;
      used         <= '0;
      single       <= '0;
      reuse        <= '0;
      sum          <= '0;
      access       <= '0;
      result_valid <= 1'b0;
    end else begin
      if (state == prip_pkg::ST_RESULT && (!result_valid || result_ready)) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        prip_pkg::ST_CLEAR: begin
          clr_idx <= (clr_idx == LAST_IDX) ? '0 : clr_idx + 1'b1;
        end
        prip_pkg::ST_UPDATE: begin
          if (access != '1) begin
            access <= access + 1'b1;
          end
          if (hit) begin
            if (reuse != '1) begin
              reuse <= reuse + 1'b1;
            end
            sum <= sum_wide[SB] ? '1 : sum_wide[SB-1:0];
            if (dec_single && (single != '0)) begin
              single <= single - 1'b1;
            end
          end
          if (insert) begin
            used   <= used + 1'b1;
            single <= single + 1'b1;
          end
        end
        prip_pkg::ST_RESULT: begin
          if (!result_valid || result_ready) begin
            if (cur.trace_end) begin
              clr_idx <= '0;
              used    <= '0;
              single  <= '0;
              reuse   <= '0;
              sum     <= '0;
              access  <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Per-beat working registers and the result register.
  always_ff @(posedge clk) begin
    unique case (state)
      prip_pkg::ST_IDLE: begin
        if (item_valid) begin
          cur       <= item;
          probe_idx <= hash_idx;
          probes    <= '0;
          hit       <= 1'b0;
          insert    <= 1'b0;
          interval  <= '0;
        end
      end
      prip_pkg::ST_CHECK: begin
        if (match) begin
          hit        <= 1'b1;
          dec_single <= !rd_entry.seen_again;
          interval   <= cur.access_time - rd_entry.last_time;
        end else if (!rd_entry.valid) begin
          insert <= 1'b1;
        end else if (probes != LAST_PROBE) begin
          probe_idx <= (probe_idx == LAST_IDX) ? '0 : probe_idx + 1'b1;
          probes    <= probes + 1'b1;
        end
      end
      prip_pkg::ST_UPDATE: begin
        mean <= '0;
      end
      prip_pkg::ST_DIVIDE: begin
        if (div_done) begin
          mean <= (|div_quotient[SB-1:TB]) ? '1 : div_quotient[TB-1:0];
        end
      end
      prip_pkg::ST_RESULT: begin
        if (!result_valid || result_ready) begin
          result.first_touch    <= !hit;
          result.reuse_interval <= interval;
          result.stored_pages   <= OCB'(used);
          result.single_pages   <= OCB'(single);
          result.reuse_total    <= reuse;
          result.interval_sum   <= sum;
          result.access_total   <= access;
          result.mean_interval  <= mean;
          result.table_overflow <= !hit && !insert;
          result.final_result   <= cur.trace_end;
        end
      end
      default: begin
      end
    endcase
  end

  a_single_within_used: assert property (@(posedge clk) disable iff (rst)
    single <= used)
    else $error("single-access page count exceeds stored page count");

  a_used_within_table: assert property (@(posedge clk) disable iff (rst)
    used <= CNT_BITS'(TABLE_ENTRIES))
    else $error("stored page count exceeds table size");

  a_probe_advances: assert property (@(posedge clk) disable iff (rst)
    (state == prip_pkg::ST_CHECK && !probe_end) |=>
      (probes == CNT_BITS'($past(probes) + 1'b1)))
    else $error("probe counter did not advance on a table miss");

  a_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == prip_pkg::ST_DIVIDE))
    else $error("divider finished outside the divide state");

  a_result_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == prip_pkg::ST_RESULT))
    else $error("result beat raised outside the result state");

endmodule

`default_nettype wire
